FILE: rtl/cnsp_pkg.sv
// Package: shared types, constants and helper functions for the cpio newc stream parser.
package cnsp_pkg;

  localparam int unsigned HDR_LEN    = 110;
  localparam int unsigned MAGIC_LEN  = 6;
  localparam int unsigned FSIZE_POS  = 54;
  localparam int unsigned NSIZE_POS  = 94;
  localparam int unsigned HEX_DIGITS = 8;
  localparam int unsigned TRL_LEN    = 10;

  localparam logic [7:0] MAGIC_TEXT [MAGIC_LEN] = '{8'h30, 8'h37, 8'h30, 8'h37, 8'h30, 8'h31};
  localparam logic [7:0] TRAILER_TEXT [TRL_LEN] = '{
    8'h54, 8'h52, 8'h41, 8'h49, 8'h4C, 8'h45, 8'h52, 8'h21, 8'h21, 8'h21
  };

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_NAME    = 3'd1,
    PH_NAMEPAD = 3'd2,
    PH_DATA    = 3'd3,
    PH_DATAPAD = 3'd4,
    PH_STOP    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ENTRY     = 2'd0,
    KIND_NAME      = 2'd1,
    KIND_DATA      = 2'd2,
    KIND_BAD_MAGIC = 2'd3
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [31:0] file_size;
    logic [31:0] name_size;
    logic        last_of_run;
    logic        is_trailer;
  } result_t;

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) v = 4'(b - 8'h30);
    else if (b >= 8'h41 && b <= 8'h46) v = 4'(b - 8'h37);
    else if (b >= 8'h61 && b <= 8'h66) v = 4'(b - 8'h57);
    return v;
  endfunction

  // (4 - ((HDR_LEN + n) & 3)) & 3
  function automatic logic [1:0] name_pad(input logic [31:0] nl);
    logic [1:0] s;
    s = nl[1:0] + 2'(HDR_LEN % 4);
    return 2'd0 - s;
  endfunction

  function automatic logic [1:0] data_pad(input logic [31:0] dl);
    return 2'd0 - dl[1:0];
  endfunction

  // Skip phases of zero length, starting at the given phase.
  function automatic phase_t skip_empty(input phase_t ph, input logic [31:0] nl,
                                        input logic [31:0] dl);
    phase_t p;
    p = ph;
    if (p == PH_NAME && nl == 32'd0) p = PH_NAMEPAD;
    if (p == PH_NAMEPAD && name_pad(nl) == 2'd0) p = PH_DATA;
    if (p == PH_DATA && dl == 32'd0) p = PH_DATAPAD;
    if (p == PH_DATAPAD && data_pad(dl) == 2'd0) p = PH_HEADER;
    return p;
  endfunction

endpackage

FILE: rtl/cnsp_parse_core.sv
// Parser state machine: record phase, byte counter, decoded sizes and trailer match.
module cnsp_parse_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step_en,
  input  logic [7:0]            step_byte,
  output cnsp_pkg::result_t     result
);

  cnsp_pkg::phase_t phase, phase_next;
  logic [31:0] position_count, position_count_next;
  logic [31:0] name_length, name_length_next;
  logic [31:0] data_length, data_length_next;
  logic        trailer_match, trailer_match_next;

  logic        in_magic, magic_bad, in_fsize, in_nsize, hdr_last;
  logic [31:0] hdr_dl, hdr_nl, dl_base, nl_base, pos_inc;
  logic [3:0]  digit;
  logic        tm_now, name_last, data_last, is_trl;
  logic        namepad_done, datapad_done;

  assign pos_inc   = position_count + 32'd1;
  assign digit     = cnsp_pkg::hex_value(step_byte);
  assign in_magic  = position_count < 32'(cnsp_pkg::MAGIC_LEN);
  assign magic_bad = in_magic && (step_byte != cnsp_pkg::MAGIC_TEXT[position_count[2:0]]);
  assign in_fsize  = position_count >= 32'(cnsp_pkg::FSIZE_POS) &&
                     position_count < 32'(cnsp_pkg::FSIZE_POS + cnsp_pkg::HEX_DIGITS);
  assign in_nsize  = position_count >= 32'(cnsp_pkg::NSIZE_POS) &&
                     position_count < 32'(cnsp_pkg::NSIZE_POS + cnsp_pkg::HEX_DIGITS);
  assign hdr_last  = position_count == 32'(cnsp_pkg::HDR_LEN - 1);

  // Clear the sizes at the first header byte of each entry.
  assign dl_base = (position_count == 32'd0) ? 32'd0 : data_length;
  assign nl_base = (position_count == 32'd0) ? 32'd0 : name_length;
  assign hdr_dl  = in_fsize ? {dl_base[27:0], digit} : dl_base;
  assign hdr_nl  = in_nsize ? {nl_base[27:0], digit} : nl_base;

  always_comb begin
    tm_now = trailer_match;
    if (position_count < 32'(cnsp_pkg::TRL_LEN)) begin
      if (step_byte != cnsp_pkg::TRAILER_TEXT[position_count[3:0]]) tm_now = 1'b0;
    end else if (position_count == 32'(cnsp_pkg::TRL_LEN)) begin
      if (step_byte != 8'd0) tm_now = 1'b0;
    end
  end

  assign name_last    = position_count == name_length - 32'd1;
  assign data_last    = position_count == data_length - 32'd1;
  assign is_trl       = tm_now && (name_length > 32'(cnsp_pkg::TRL_LEN));
  assign namepad_done = ({1'b0, position_count[1:0]} + 3'd1) >=
                        {1'b0, cnsp_pkg::name_pad(name_length)};
  assign datapad_done = ({1'b0, position_count[1:0]} + 3'd1) >=
                        {1'b0, cnsp_pkg::data_pad(data_length)};

  // Next state
  always_comb begin
    phase_next          = phase;
    position_count_next = position_count;
    name_length_next    = name_length;
    data_length_next    = data_length;
    trailer_match_next  = trailer_match;
    if (step_en) begin
      unique case (phase)
        cnsp_pkg::PH_HEADER: begin
          name_length_next = hdr_nl;
          data_length_next = hdr_dl;
          if (magic_bad) begin
            phase_next = cnsp_pkg::PH_STOP;
          end else if (hdr_last) begin
            phase_next          = cnsp_pkg::skip_empty(cnsp_pkg::PH_NAME, hdr_nl, hdr_dl);
            position_count_next = 32'd0;
            trailer_match_next  = 1'b1;
          end else begin
            position_count_next = pos_inc;
          end
        end
        cnsp_pkg::PH_NAME: begin
          trailer_match_next  = tm_now;
          position_count_next = pos_inc;
          if (name_last) begin
            if (is_trl) begin
              phase_next = cnsp_pkg::PH_STOP;
            end else begin
              phase_next = cnsp_pkg::skip_empty(cnsp_pkg::PH_NAMEPAD, name_length,
                                                data_length);
              position_count_next = 32'd0;
            end
          end
        end
        cnsp_pkg::PH_NAMEPAD: begin
          position_count_next = pos_inc;
          if (namepad_done) begin
            phase_next = cnsp_pkg::skip_empty(cnsp_pkg::PH_DATA, name_length, data_length);
            position_count_next = 32'd0;
          end
        end
        cnsp_pkg::PH_DATA: begin
          position_count_next = pos_inc;
          if (data_last) begin
            phase_next = cnsp_pkg::skip_empty(cnsp_pkg::PH_DATAPAD, name_length,
                                              data_length);
            position_count_next = 32'd0;
          end
        end
        cnsp_pkg::PH_DATAPAD: begin
          position_count_next = pos_inc;
          if (datapad_done) begin
            phase_next          = cnsp_pkg::PH_HEADER;
            position_count_next = 32'd0;
          end
        end
        cnsp_pkg::PH_STOP: begin
          phase_next = cnsp_pkg::PH_STOP;
        end
        default: begin
          phase_next = cnsp_pkg::PH_STOP;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    result = '0;
    if (step_en) begin
      unique case (phase)
        cnsp_pkg::PH_HEADER: begin
          if (magic_bad) begin
            result.valid = 1'b1;
            result.kind  = cnsp_pkg::KIND_BAD_MAGIC;
          end else if (hdr_last) begin
            result.valid     = 1'b1;
            result.kind      = cnsp_pkg::KIND_ENTRY;
            result.file_size = hdr_dl;
            result.name_size = hdr_nl;
          end
        end
        cnsp_pkg::PH_NAME: begin
          result.valid       = 1'b1;
          result.kind        = cnsp_pkg::KIND_NAME;
          result.byte_value  = step_byte;
          result.file_size   = data_length;
          result.name_size   = name_length;
          result.last_of_run = name_last;
          result.is_trailer  = name_last && is_trl;
        end
        cnsp_pkg::PH_DATA: begin
          result.valid       = 1'b1;
          result.kind        = cnsp_pkg::KIND_DATA;
          result.byte_value  = step_byte;
          result.file_size   = data_length;
          result.name_size   = name_length;
          result.last_of_run = data_last;
        end
        cnsp_pkg::PH_NAMEPAD, cnsp_pkg::PH_DATAPAD, cnsp_pkg::PH_STOP: begin
          result.valid = 1'b0;
        end
        default: begin
          result.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= cnsp_pkg::PH_HEADER;
      position_count <= 32'd0;
      name_length    <= 32'd0;
      data_length    <= 32'd0;
      trailer_match  <= 1'b1;
    end else begin
      phase          <= phase_next;
      position_count <= position_count_next;
      name_length    <= name_length_next;
      data_length    <= data_length_next;
      trailer_match  <= trailer_match_next;
    end
  end

endmodule

FILE: rtl/cpio_newc_stream_parser_unit.sv
// Top level: input register, parser core and result register of the cpio newc stream parser.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_stall  | archive_byte
//  out     | out_valid / out_stall| result_kind, byte_value, entry_file_size,
//          |                      | entry_name_size, last_of_run, is_trailer
//
// One byte is taken every cycle while in_valid is high and in_stall is low; it passes through the
// input register and then the result register, and out_valid rises for each byte that gives a result.
// The parser state advances once per byte in a single pass between the input register
// and the result register, so the rate is one byte per cycle while out_stall holds no result.
// Reset (synchronous, rst high) returns the parser to the start of a header.
// A held result under out_stall holds the byte in the input register, and in_stall
// rises only while both registers are full.
module cpio_newc_stream_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  archive_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  byte_value,
  output logic [31:0] entry_file_size,
  output logic [31:0] entry_name_size,
  output logic        last_of_run,
  output logic        is_trailer
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              slot_free, step_en, in_take;
  cnsp_pkg::result_t res;

  assign slot_free = !out_valid || !out_stall;
  assign step_en   = in_full && slot_free;
  assign in_stall  = in_full && !slot_free;
  assign in_take   = in_valid && !in_stall;

  cnsp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (step_en),
    .step_byte (in_byte),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (step_en) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= archive_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res.valid;
    end
  end

  // Load payload only with a new result; hold it while stalled.
  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      result_kind     <= res.kind;
      byte_value      <= res.byte_value;
      entry_file_size <= res.file_size;
      entry_name_size <= res.name_size;
      last_of_run     <= res.last_of_run;
      is_trailer      <= res.is_trailer;
    end
  end

endmodule
